// ===== hw/rtl/pfd_pkg.sv =====
// shared types, constants and register codes of the pt100 fan duty block
package pfd_pkg;

    // sample and fixed-point formats
    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 20;

    // derived widths
    localparam int TEMP_W    = FRACTION_BITS + 12;              // signed temperature / average
    localparam int MAG_W     = SAMPLE_BITS + 18;                // |220000*s - 20000*full|
    localparam int DEN_W     = SAMPLE_BITS + 7;                 // 77*(full - s)
    localparam int Y_W       = SAMPLE_BITS + 8;                 // divisor width
    localparam int X_W       = SAMPLE_BITS + FRACTION_BITS + 20; // dividend width
    localparam int Q_W       = 2 * ((FRACTION_BITS + 13) / 2);  // quotient width, even
    localparam int DIV_STEPS = Q_W / 2;                         // two quotient bits per cycle
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int HOT_W     = 15;
    localparam int THR_W     = 14;
    localparam int DUTY_W    = 9;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // conversion constants
    localparam int unsigned FULL_SCALE = 1 << SAMPLE_BITS;
    localparam logic [MAG_W-1:0] RES_GAIN   = MAG_W'(220000);
    localparam logic [MAG_W-1:0] RES_OFFSET = MAG_W'(20000) << SAMPLE_BITS;
    localparam logic [DEN_W-1:0] DEN_GAIN   = DEN_W'(77);
    localparam logic [Q_W-1:0]   SAT_Q      = Q_W'(16383) << (FRACTION_BITS - 4);

    // averaging: round(delta / 10000) as (2*|delta| + 10000) / 20000
    localparam logic [X_W-1:0] EMA_HALF = X_W'(10000);
    localparam logic [Y_W-1:0] EMA_DIV  = Y_W'(20000);

    localparam logic signed [TEMP_W-1:0] AVG_RESET = TEMP_W'(27) << FRACTION_BITS;

    // register reset values
    localparam logic [THR_W-1:0]  TEMP_OFF_RST  = THR_W'(528);
    localparam logic [THR_W-1:0]  TEMP_HOLD_RST = THR_W'(560);
    localparam logic [THR_W-1:0]  TEMP_LOW_RST  = THR_W'(672);
    localparam logic [THR_W-1:0]  TEMP_MID_RST  = THR_W'(728);
    localparam logic [DUTY_W-1:0] DUTY_LOW_RST  = DUTY_W'(250);
    localparam logic [DUTY_W-1:0] DUTY_MID_RST  = DUTY_W'(375);
    localparam logic [DUTY_W-1:0] DUTY_HIGH_RST = DUTY_W'(499);

    // register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_TEMP_OFF  = 3'd0,
        REG_TEMP_HOLD = 3'd1,
        REG_TEMP_LOW  = 3'd2,
        REG_TEMP_MID  = 3'd3,
        REG_DUTY_LOW  = 3'd4,
        REG_DUTY_MID  = 3'd5,
        REG_DUTY_HIGH = 3'd6
    } t_reg_idx;

    // divider operations
    typedef enum logic [1:0] {
        OP_TEMP_A = 2'd0,
        OP_TEMP_B = 2'd1,
        OP_EMA_A  = 2'd2,
        OP_EMA_B  = 2'd3
    } t_op;

    typedef struct packed {
        logic [THR_W-1:0]  temp_off;
        logic [THR_W-1:0]  temp_hold;
        logic [THR_W-1:0]  temp_low_limit;
        logic [THR_W-1:0]  temp_mid_limit;
        logic [DUTY_W-1:0] duty_low;
        logic [DUTY_W-1:0] duty_mid;
        logic [DUTY_W-1:0] duty_high;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic store;
        t_op  op;
        logic hot;
        logic duty_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/pfd_in_if.sv =====
// input channel: two sensor samples per transaction
interface pfd_in_if;
    logic                             valid;
    logic                             ready;
    logic [pfd_pkg::SAMPLE_BITS-1:0]  sample_a;
    logic [pfd_pkg::SAMPLE_BITS-1:0]  sample_b;

    modport source (output valid, output sample_a, output sample_b, input ready);
    modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

// ===== hw/rtl/pfd_out_if.sv =====
// output channel: fan duty and hottest smoothed temperature
interface pfd_out_if;
    logic                              valid;
    logic                              ready;
    logic [pfd_pkg::DUTY_W-1:0]        fan_duty;
    logic signed [pfd_pkg::HOT_W-1:0]  hottest_temp;

    modport source (output valid, output fan_duty, output hottest_temp, input ready);
    modport sink   (input valid, input fan_duty, input hottest_temp, output ready);
endinterface

// ===== hw/rtl/pt100_smoothed_fan_duty_control.sv =====
// top level: two-sensor pt100 smoothing with stepped fan duty and apb registers
//
//  channel   dir   handshake          payload
//  i_in      in    valid / ready      sample_a[11:0], sample_b[11:0]
//  o_out     out   valid / ready      fan_duty[8:0], hottest_temp[14:0] signed
//  apb       in    psel / penable     paddr[4:0], pwdata[31:0], prdata[31:0]
//
//  one transaction makes four passes through the shared two-bit-per-cycle
//  divider, one for each temperature and one for each average.
//  input ready is high only while the controller is idle; a finished result
//  waits in the output register and the next transaction is taken meanwhile.
//  a stalled output holds the controller in its duty step until the slot frees.
//  synchronous active-low reset restores the registers, both averages to 27 C
//  and the held duty to zero.
module pt100_smoothed_fan_duty_control (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pfd_in_if.sink                              i_in,
    pfd_out_if.source                           o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pfd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [pfd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pfd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    pfd_pkg::t_cfg   r_cfg;
    pfd_pkg::t_cmd   cmd;
    pfd_pkg::t_stat  stat;
    pfd_pkg::t_reg_idx reg_idx;
    logic            cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = pfd_pkg::t_reg_idx'(paddr[pfd_pkg::APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_off       <= pfd_pkg::TEMP_OFF_RST;
            r_cfg.temp_hold      <= pfd_pkg::TEMP_HOLD_RST;
            r_cfg.temp_low_limit <= pfd_pkg::TEMP_LOW_RST;
            r_cfg.temp_mid_limit <= pfd_pkg::TEMP_MID_RST;
            r_cfg.duty_low       <= pfd_pkg::DUTY_LOW_RST;
            r_cfg.duty_mid       <= pfd_pkg::DUTY_MID_RST;
            r_cfg.duty_high      <= pfd_pkg::DUTY_HIGH_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                pfd_pkg::REG_TEMP_OFF:  r_cfg.temp_off       <= pwdata[pfd_pkg::THR_W-1:0];
                pfd_pkg::REG_TEMP_HOLD: r_cfg.temp_hold      <= pwdata[pfd_pkg::THR_W-1:0];
                pfd_pkg::REG_TEMP_LOW:  r_cfg.temp_low_limit <= pwdata[pfd_pkg::THR_W-1:0];
                pfd_pkg::REG_TEMP_MID:  r_cfg.temp_mid_limit <= pwdata[pfd_pkg::THR_W-1:0];
                pfd_pkg::REG_DUTY_LOW:  r_cfg.duty_low       <= pwdata[pfd_pkg::DUTY_W-1:0];
                pfd_pkg::REG_DUTY_MID:  r_cfg.duty_mid       <= pwdata[pfd_pkg::DUTY_W-1:0];
                pfd_pkg::REG_DUTY_HIGH: r_cfg.duty_high      <= pwdata[pfd_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            pfd_pkg::REG_TEMP_OFF:  prdata = pfd_pkg::APB_DATA_W'(r_cfg.temp_off);
            pfd_pkg::REG_TEMP_HOLD: prdata = pfd_pkg::APB_DATA_W'(r_cfg.temp_hold);
            pfd_pkg::REG_TEMP_LOW:  prdata = pfd_pkg::APB_DATA_W'(r_cfg.temp_low_limit);
            pfd_pkg::REG_TEMP_MID:  prdata = pfd_pkg::APB_DATA_W'(r_cfg.temp_mid_limit);
            pfd_pkg::REG_DUTY_LOW:  prdata = pfd_pkg::APB_DATA_W'(r_cfg.duty_low);
            pfd_pkg::REG_DUTY_MID:  prdata = pfd_pkg::APB_DATA_W'(r_cfg.duty_mid);
            pfd_pkg::REG_DUTY_HIGH: prdata = pfd_pkg::APB_DATA_W'(r_cfg.duty_high);
            default:                prdata = '0;
        endcase
    end

    pfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pfd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg          (r_cfg),
        .i_sample_a     (i_in.sample_a),
        .i_sample_b     (i_in.sample_b),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_fan_duty     (o_out.fan_duty),
        .o_hottest_temp (o_out.hottest_temp)
    );

endmodule

// ===== hw/rtl/pfd_div.sv =====
// shared restoring divider, two quotient bits per cycle, with overflow flag
module pfd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pfd_pkg::X_W-1:0]     i_x,
    input  logic [pfd_pkg::Y_W-1:0]     i_y,
    output logic                        o_done,
    output logic                        o_ovf,
    output logic [pfd_pkg::Q_W-1:0]     o_q
);

    logic                        r_busy;
    logic                        r_done;
    logic [pfd_pkg::CNT_W-1:0]   r_cnt;
    logic [pfd_pkg::Y_W-1:0]     r_rem;
    logic [pfd_pkg::Q_W-1:0]     r_num;
    logic [pfd_pkg::Y_W-1:0]     r_y;
    logic                        r_ovf;

    logic [pfd_pkg::Y_W-1:0]     n_rem;
    logic [pfd_pkg::Q_W-1:0]     n_num;
    logic [pfd_pkg::X_W-1:0]     upper;

    // high part of the dividend, must stay below the divisor
    assign upper = i_x >> pfd_pkg::Q_W;

    // two compare-subtract steps
    always_comb begin
        logic [pfd_pkg::Y_W:0] trial;
        logic                  ge;
        n_rem = r_rem;
        n_num = r_num;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_num[pfd_pkg::Q_W-1]};
            ge    = (trial >= {1'b0, r_y});
            if (ge) begin
                trial = trial - {1'b0, r_y};
            end
            n_rem = trial[pfd_pkg::Y_W-1:0];
            n_num = {n_num[pfd_pkg::Q_W-2:0], ge};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pfd_pkg::CNT_W'(pfd_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - pfd_pkg::CNT_W'(1);
                if (r_cnt == pfd_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= upper[pfd_pkg::Y_W-1:0];
            r_num <= i_x[pfd_pkg::Q_W-1:0];
            r_y   <= i_y;
            r_ovf <= (upper >= pfd_pkg::X_W'(i_y));
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= n_num;
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_q    = r_num;

endmodule

// ===== hw/rtl/pfd_dp.sv =====
// datapath: operand forming, averages, duty ladder and output register
module pfd_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pfd_pkg::t_cmd                       i_cmd,
    output pfd_pkg::t_stat                      o_stat,
    input  pfd_pkg::t_cfg                       i_cfg,
    input  logic [pfd_pkg::SAMPLE_BITS-1:0]     i_sample_a,
    input  logic [pfd_pkg::SAMPLE_BITS-1:0]     i_sample_b,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [pfd_pkg::DUTY_W-1:0]          o_fan_duty,
    output logic signed [pfd_pkg::HOT_W-1:0]    o_hottest_temp
);

    logic [pfd_pkg::SAMPLE_BITS-1:0]     r_sa;
    logic [pfd_pkg::SAMPLE_BITS-1:0]     r_sb;
    logic                                r_neg;
    logic signed [pfd_pkg::TEMP_W-1:0]   r_t_a;
    logic signed [pfd_pkg::TEMP_W-1:0]   r_t_b;
    logic signed [pfd_pkg::TEMP_W-1:0]   r_avg_a;
    logic signed [pfd_pkg::TEMP_W-1:0]   r_avg_b;
    logic signed [pfd_pkg::HOT_W-1:0]    r_h;
    logic [pfd_pkg::DUTY_W-1:0]          r_held;
    logic                                r_out_valid;
    logic [pfd_pkg::DUTY_W-1:0]          r_out_duty;
    logic signed [pfd_pkg::HOT_W-1:0]    r_out_hot;

    logic [pfd_pkg::X_W-1:0]             div_x;
    logic [pfd_pkg::Y_W-1:0]             div_y;
    logic                                div_neg;
    logic                                div_done;
    logic                                div_ovf;
    logic [pfd_pkg::Q_W-1:0]             div_q;

    logic [pfd_pkg::SAMPLE_BITS-1:0]     s_sel;
    logic [pfd_pkg::SAMPLE_BITS:0]       span;
    logic [pfd_pkg::MAG_W-1:0]           prod;
    logic [pfd_pkg::MAG_W-1:0]           res_mag;
    logic [pfd_pkg::DEN_W-1:0]           den;
    logic signed [pfd_pkg::TEMP_W:0]     delta;
    logic [pfd_pkg::TEMP_W:0]            delta_mag;

    logic [pfd_pkg::TEMP_W-1:0]          q_low;
    logic signed [pfd_pkg::TEMP_W-1:0]   t_val;
    logic signed [pfd_pkg::TEMP_W-1:0]   avg_sel;
    logic signed [pfd_pkg::TEMP_W-1:0]   avg_new;
    logic signed [pfd_pkg::TEMP_W-1:0]   hot;
    logic signed [pfd_pkg::TEMP_W-1:0]   hot_shift;
    logic signed [pfd_pkg::HOT_W:0]      h_ext;
    logic [pfd_pkg::DUTY_W-1:0]          duty;

    // resistance ratio terms of the selected sample
    assign s_sel   = (i_cmd.op == pfd_pkg::OP_TEMP_B) ? r_sb : r_sa;
    assign span    = (pfd_pkg::SAMPLE_BITS + 1)'(pfd_pkg::FULL_SCALE) - {1'b0, s_sel};
    assign prod    = pfd_pkg::RES_GAIN * pfd_pkg::MAG_W'(s_sel);
    assign den     = pfd_pkg::DEN_GAIN * pfd_pkg::DEN_W'(span);
    assign res_mag = (prod < pfd_pkg::RES_OFFSET) ? (pfd_pkg::RES_OFFSET - prod)
                                                  : (prod - pfd_pkg::RES_OFFSET);

    // difference of new temperature and running average
    assign avg_sel   = (i_cmd.op == pfd_pkg::OP_EMA_B) ? r_avg_b : r_avg_a;
    assign delta     = ((i_cmd.op == pfd_pkg::OP_EMA_B) ? {r_t_b[pfd_pkg::TEMP_W-1], r_t_b}
                                                        : {r_t_a[pfd_pkg::TEMP_W-1], r_t_a})
                     - {avg_sel[pfd_pkg::TEMP_W-1], avg_sel};
    assign delta_mag = delta[pfd_pkg::TEMP_W] ? ($unsigned(-delta)) : $unsigned(delta);

    // divider operand select
    always_comb begin
        unique case (i_cmd.op)
            pfd_pkg::OP_TEMP_A, pfd_pkg::OP_TEMP_B: begin
                div_neg = (prod < pfd_pkg::RES_OFFSET);
                div_x   = (pfd_pkg::X_W'(res_mag) << (pfd_pkg::FRACTION_BITS + 1))
                        + pfd_pkg::X_W'(den);
                div_y   = {den, 1'b0};
            end
            default: begin
                div_neg = delta[pfd_pkg::TEMP_W];
                div_x   = (pfd_pkg::X_W'(delta_mag) << 1) + pfd_pkg::EMA_HALF;
                div_y   = pfd_pkg::EMA_DIV;
            end
        endcase
    end

    pfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_x     (div_x),
        .i_y     (div_y),
        .o_done  (div_done),
        .o_ovf   (div_ovf),
        .o_q     (div_q)
    );

    // signed temperature with upper saturation, and average step
    assign q_low   = div_q[pfd_pkg::TEMP_W-1:0];
    assign t_val   = r_neg ? $signed(pfd_pkg::TEMP_W'(0) - q_low)
                   : ((div_ovf || (div_q > pfd_pkg::SAT_Q))
                      ? $signed(pfd_pkg::SAT_Q[pfd_pkg::TEMP_W-1:0]) : $signed(q_low));
    assign avg_new = r_neg ? (avg_sel - $signed(q_low)) : (avg_sel + $signed(q_low));

    // larger average in sixteenths, floor
    assign hot       = (r_avg_a > r_avg_b) ? r_avg_a : r_avg_b;
    assign hot_shift = hot >>> (pfd_pkg::FRACTION_BITS - 4);

    // duty ladder, first true compare wins
    assign h_ext = {r_h[pfd_pkg::HOT_W-1], r_h};
    always_comb begin
        if (h_ext < $signed({2'b00, i_cfg.temp_off})) begin
            duty = '0;
        end else if (h_ext < $signed({2'b00, i_cfg.temp_hold})) begin
            duty = r_held;
        end else if (h_ext < $signed({2'b00, i_cfg.temp_low_limit})) begin
            duty = i_cfg.duty_low;
        end else if (h_ext < $signed({2'b00, i_cfg.temp_mid_limit})) begin
            duty = i_cfg.duty_mid;
        end else begin
            duty = i_cfg.duty_high;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sa <= i_sample_a;
            r_sb <= i_sample_b;
        end
        if (i_cmd.div_start) begin
            r_neg <= div_neg;
        end
        if (i_cmd.store && (i_cmd.op == pfd_pkg::OP_TEMP_A)) begin
            r_t_a <= t_val;
        end
        if (i_cmd.store && (i_cmd.op == pfd_pkg::OP_TEMP_B)) begin
            r_t_b <= t_val;
        end
        if (i_cmd.hot) begin
            r_h <= hot_shift[pfd_pkg::HOT_W-1:0];
        end
        if (i_cmd.duty_load) begin
            r_out_duty <= duty;
            r_out_hot  <= r_h;
        end
    end

    // averages, held duty and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_a     <= pfd_pkg::AVG_RESET;
            r_avg_b     <= pfd_pkg::AVG_RESET;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store && (i_cmd.op == pfd_pkg::OP_EMA_A)) begin
                r_avg_a <= avg_new;
            end
            if (i_cmd.store && (i_cmd.op == pfd_pkg::OP_EMA_B)) begin
                r_avg_b <= avg_new;
            end
            if (i_cmd.duty_load) begin
                r_held      <= duty;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_fan_duty      = r_out_duty;
    assign o_hottest_temp  = r_out_hot;

endmodule

// ===== hw/rtl/pfd_ctrl.sv =====
// controller: sequences the four divisions, the max and the duty step
module pfd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pfd_pkg::t_stat  i_stat,
    output pfd_pkg::t_cmd   o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_TA_GO  = 11'b000_0000_0010,
        S_TA_RUN = 11'b000_0000_0100,
        S_EA_GO  = 11'b000_0000_1000,
        S_EA_RUN = 11'b000_0001_0000,
        S_TB_GO  = 11'b000_0010_0000,
        S_TB_RUN = 11'b000_0100_0000,
        S_EB_GO  = 11'b000_1000_0000,
        S_EB_RUN = 11'b001_0000_0000,
        S_HOT    = 11'b010_0000_0000,
        S_DUTY   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.op         = pfd_pkg::OP_TEMP_A;
        o_in_ready       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_TA_GO;
                end
            end
            S_TA_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_TA_RUN;
            end
            S_TA_RUN: begin
                o_cmd.store = i_stat.div_done;
                if (i_stat.div_done) begin
                    n_state = S_EA_GO;
                end
            end
            S_EA_GO: begin
                o_cmd.op        = pfd_pkg::OP_EMA_A;
                o_cmd.div_start = 1'b1;
                n_state         = S_EA_RUN;
            end
            S_EA_RUN: begin
                o_cmd.op    = pfd_pkg::OP_EMA_A;
                o_cmd.store = i_stat.div_done;
                if (i_stat.div_done) begin
                    n_state = S_TB_GO;
                end
            end
            S_TB_GO: begin
                o_cmd.op        = pfd_pkg::OP_TEMP_B;
                o_cmd.div_start = 1'b1;
                n_state         = S_TB_RUN;
            end
            S_TB_RUN: begin
                o_cmd.op    = pfd_pkg::OP_TEMP_B;
                o_cmd.store = i_stat.div_done;
                if (i_stat.div_done) begin
                    n_state = S_EB_GO;
                end
            end
            S_EB_GO: begin
                o_cmd.op        = pfd_pkg::OP_EMA_B;
                o_cmd.div_start = 1'b1;
                n_state         = S_EB_RUN;
            end
            S_EB_RUN: begin
                o_cmd.op    = pfd_pkg::OP_EMA_B;
                o_cmd.store = i_stat.div_done;
                if (i_stat.div_done) begin
                    n_state = S_HOT;
                end
            end
            S_HOT: begin
                o_cmd.hot = 1'b1;
                n_state   = S_DUTY;
            end
            S_DUTY: begin
                o_cmd.duty_load = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/pfd_checker.sv =====
// port-level checks of the fan duty block, bound to the top level
module pfd_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [pfd_pkg::DUTY_W-1:0]         i_fan_duty,
    input  logic signed [pfd_pkg::HOT_W-1:0]   i_hottest_temp
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_fan_duty) && $stable(i_hottest_temp)))
        else $error("output transaction changed while stalled");

    // one transaction in flight: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input accepted while a transaction is in work");

    // a result cannot appear right after its transaction is taken
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ##1 !$rose(i_out_valid))
        else $error("result delivered too early");

    // smoothed temperature stays above the sensor floor
    a_hot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_hottest_temp >= -15'sd4160))
        else $error("hottest temperature out of range");

endmodule

bind pt100_smoothed_fan_duty_control pfd_checker u_pfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_fan_duty     (o_out.fan_duty),
    .i_hottest_temp (o_out.hottest_temp)
);
